### design/stack_queue_command_engine_unit_defines.svh
// assertion macros for the command engine checker
`ifndef STACK_QUEUE_COMMAND_ENGINE_UNIT_DEFINES_SVH
`define STACK_QUEUE_COMMAND_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SQCE_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define SQCE_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### design/sqce_pkg.sv
// shared types, codes and constants of the stack/queue command engine
package sqce_pkg;

    localparam int SQCE_DEPTH = 64;

    typedef enum logic [2:0] {
        REQ_PUSH = 3'd0,
        REQ_POP  = 3'd1,
        REQ_SWAP = 3'd2,
        REQ_PEEK = 3'd3,
        REQ_DUMP = 3'd4
    } req_code_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SWAP_SHORT = 3'd1,
        ST_PEEK_EMPTY = 3'd2,
        ST_POP_EMPTY  = 3'd3,
        ST_PUSH_FULL  = 3'd4
    } status_code_t;

    typedef enum logic [1:0] {
        ADDR_TOP,
        ADDR_NEXT,
        ADDR_PUSH,
        ADDR_DUMP
    } addr_sel_t;

    typedef enum logic [1:0] {
        WR_PUSH,
        WR_RDATA,
        WR_TEMP
    } wr_src_t;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_PUSH,
        UPD_POP
    } upd_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] push_value;
    } sqce_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               has_value;
        logic signed [31:0] out_value;
        logic               last;
    } sqce_out_t;

    // controller to datapath
    typedef struct packed {
        logic         load_value;
        logic         mem_rd;
        logic         mem_wr;
        addr_sel_t    addr_sel;
        wr_src_t      wr_src;
        logic         temp_load;
        upd_t         upd;
        logic         dump_clr;
        logic         dump_inc;
        logic         out_load;
        status_code_t out_status;
        logic         out_from_mem;
        logic         out_last;
    } sqce_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic two_or_more;
        logic dump_done;
    } sqce_stat_t;

endpackage

### design/sqce_ctrl.sv
// controller state machine of the command engine
module sqce_ctrl
    import sqce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [2:0] req_type,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output sqce_cmd_t  cmd,
    input  sqce_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SWAP_B,
        S_SWAP_WA,
        S_SWAP_WB,
        S_PEEK_OUT,
        S_DUMP_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] req_type_reg;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       out_free;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_value = 1'b1;
                    cmd.dump_clr   = 1'b1;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (req_type_reg)
                    REQ_PUSH:
                    begin
                        if (out_free)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_last   = 1'b1;
                            cmd.out_status = stat.full ? ST_PUSH_FULL : ST_OK;
                            if (!stat.full)
                            begin
                                cmd.mem_wr   = 1'b1;
                                cmd.addr_sel = ADDR_PUSH;
                                cmd.wr_src   = WR_PUSH;
                                cmd.upd      = UPD_PUSH;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    REQ_POP:
                    begin
                        if (out_free)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_last   = 1'b1;
                            cmd.out_status = stat.empty ? ST_POP_EMPTY : ST_OK;
                            if (!stat.empty)
                                cmd.upd = UPD_POP;
                            state_next = S_IDLE;
                        end
                    end
                    REQ_SWAP:
                    begin
                        if (stat.two_or_more)
                        begin
                            cmd.mem_rd   = 1'b1;
                            cmd.addr_sel = ADDR_TOP;
                            state_next   = S_SWAP_B;
                        end
                        else if (out_free)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_last   = 1'b1;
                            cmd.out_status = ST_SWAP_SHORT;
                            state_next     = S_IDLE;
                        end
                    end
                    REQ_PEEK:
                    begin
                        if (!stat.empty)
                        begin
                            cmd.mem_rd   = 1'b1;
                            cmd.addr_sel = ADDR_TOP;
                            state_next   = S_PEEK_OUT;
                        end
                        else if (out_free)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_last   = 1'b1;
                            cmd.out_status = ST_PEEK_EMPTY;
                            state_next     = S_IDLE;
                        end
                    end
                    REQ_DUMP:
                    begin
                        if (!stat.empty)
                        begin
                            cmd.mem_rd   = 1'b1;
                            cmd.addr_sel = ADDR_DUMP;
                            cmd.dump_inc = 1'b1;
                            state_next   = S_DUMP_OUT;
                        end
                        else if (out_free)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_last   = 1'b1;
                            cmd.out_status = ST_OK;
                            state_next     = S_IDLE;
                        end
                    end
                    default:
                    begin
                        // unused codes: plain ok, no state change
                        if (out_free)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_last   = 1'b1;
                            cmd.out_status = ST_OK;
                            state_next     = S_IDLE;
                        end
                    end
                endcase
            end
            S_SWAP_B:
            begin
                cmd.mem_rd    = 1'b1;
                cmd.addr_sel  = ADDR_NEXT;
                cmd.temp_load = 1'b1;
                state_next    = S_SWAP_WA;
            end
            S_SWAP_WA:
            begin
                cmd.mem_wr   = 1'b1;
                cmd.addr_sel = ADDR_TOP;
                cmd.wr_src   = WR_RDATA;
                state_next   = S_SWAP_WB;
            end
            S_SWAP_WB:
            begin
                if (out_free)
                begin
                    cmd.mem_wr     = 1'b1;
                    cmd.addr_sel   = ADDR_NEXT;
                    cmd.wr_src     = WR_TEMP;
                    cmd.out_load   = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.out_status = ST_OK;
                    state_next     = S_IDLE;
                end
            end
            S_PEEK_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_last     = 1'b1;
                    cmd.out_from_mem = 1'b1;
                    cmd.out_status   = ST_OK;
                    state_next       = S_IDLE;
                end
            end
            S_DUMP_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_from_mem = 1'b1;
                    cmd.out_status   = ST_OK;
                    cmd.out_last     = stat.dump_done;
                    if (stat.dump_done)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.mem_rd   = 1'b1;
                        cmd.addr_sel = ADDR_DUMP;
                        cmd.dump_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = cmd.out_load || (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_type_reg  <= 3'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (req_valid && req_ready)
                req_type_reg <= req_type;
        end
    end

endmodule

### design/sqce_datapath.sv
// datapath: entry memory, top index, fill count, dump counter, result register
module sqce_datapath
    import sqce_pkg::*;
#(
    parameter int DEPTH = SQCE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic signed [31:0] push_value,
    input  sqce_cmd_t          cmd,
    output sqce_stat_t         stat,
    output sqce_out_t          rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [31:0]   mem [DEPTH];
    logic [AW-1:0] top_reg, top_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] k_reg, k_next;
    logic          mode_reg;
    logic [31:0]   val_reg;
    logic [31:0]   temp_reg;
    logic [31:0]   rd_data_reg;
    sqce_out_t     out_reg;

    logic [AW-1:0] off;
    logic [AW:0]   sum;
    logic [AW:0]   sum_wrap;
    logic [AW:0]   inc;
    logic [AW:0]   inc_wrap;
    logic [AW-1:0] top_minus1;
    logic [AW-1:0] addr;
    logic [31:0]   wdata;

    always_comb
    begin
        unique case (cmd.addr_sel)
            ADDR_TOP:  off = '0;
            ADDR_NEXT: off = AW'(1);
            ADDR_PUSH: off = cnt_reg[AW-1:0];
            ADDR_DUMP: off = k_reg[AW-1:0];
            default:   off = '0;
        endcase
    end

    // circular offset from the top slot
    assign sum      = {1'b0, top_reg} + {1'b0, off};
    assign sum_wrap = (sum >= DEPTH_W) ? (sum - DEPTH_W) : sum;
    assign inc      = {1'b0, top_reg} + (AW + 1)'(1);
    assign inc_wrap = (inc >= DEPTH_W) ? (inc - DEPTH_W) : inc;
    assign top_minus1 = (top_reg == '0) ? AW'(DEPTH - 1) : (top_reg - AW'(1));

    assign addr = (cmd.addr_sel == ADDR_PUSH && !mode_reg) ? top_minus1 : sum_wrap[AW-1:0];

    always_comb
    begin
        unique case (cmd.wr_src)
            WR_PUSH:  wdata = val_reg;
            WR_RDATA: wdata = rd_data_reg;
            WR_TEMP:  wdata = temp_reg;
            default:  wdata = val_reg;
        endcase
    end

    always_comb
    begin
        top_next = top_reg;
        cnt_next = cnt_reg;
        unique case (cmd.upd)
            UPD_PUSH:
            begin
                if (!mode_reg)
                    top_next = top_minus1;
                cnt_next = cnt_reg + CW'(1);
            end
            UPD_POP:
            begin
                top_next = inc_wrap[AW-1:0];
                cnt_next = cnt_reg - CW'(1);
            end
            default:
            begin
                top_next = top_reg;
            end
        endcase
    end

    always_comb
    begin
        k_next = k_reg;
        if (cmd.dump_clr)
            k_next = '0;
        else if (cmd.dump_inc)
            k_next = k_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg  <= '0;
            cnt_reg  <= '0;
            k_reg    <= '0;
            mode_reg <= 1'b0;
        end
        else
        begin
            top_reg <= top_next;
            cnt_reg <= cnt_next;
            k_reg   <= k_next;
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
        end
    end

    // payload registers and entry memory
    always_ff @(posedge clk)
    begin
        if (cmd.load_value)
            val_reg <= push_value;
        if (cmd.temp_load)
            temp_reg <= rd_data_reg;
        if (cmd.mem_rd)
            rd_data_reg <= mem[addr];
        if (cmd.mem_wr)
            mem[addr] <= wdata;
        if (cmd.out_load)
        begin
            out_reg.status    <= cmd.out_status;
            out_reg.has_value <= cmd.out_from_mem;
            out_reg.out_value <= cmd.out_from_mem ? rd_data_reg : 32'd0;
            out_reg.last      <= cmd.out_last;
        end
    end

    assign stat.empty       = (cnt_reg == '0);
    assign stat.full        = (cnt_reg == DEPTH_C);
    assign stat.two_or_more = (cnt_reg >= CW'(2));
    assign stat.dump_done   = (k_reg == cnt_reg);
    assign rsp              = out_reg;

endmodule

### design/stack_queue_command_engine_unit.sv
// push, pop, short swap, empty peek/dump and unused codes load their result in the execute state
// peek with data reads the top entry first; swap does two reads then two writes on the single memory port
// dump: results follow one per cycle while the result channel is not stalled, paced by the memory read port
// one transaction at a time: next request taken once the last result sits in the output register
// reset (rst_n, async, active low) empties the store and clears insert mode to stack; entry contents
// are not cleared, only live entries are read
module stack_queue_command_engine_unit
    import sqce_pkg::*;
#(
    parameter int DEPTH = SQCE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    // configuration: insert mode, 0 stack, 1 queue
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    // request channel
    input  logic      req_valid,
    output logic      req_ready,
    input  sqce_in_t  req,
    // result channel
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output sqce_out_t rsp
);

    // command and status between controller and datapath
    sqce_cmd_t  cmd;
    sqce_stat_t stat;

    // controller: sequences each transaction, owns the result valid flag
    sqce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req.req_type),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // datapath: circular entry store with registered read, top index and fill count
    sqce_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push_value  (req.push_value),
        .cmd         (cmd),
        .stat        (stat),
        .rsp         (rsp)
    );

endmodule

### design/sqce_checker.sv
// port-level checker for the command engine, bound to the top level
`include "stack_queue_command_engine_unit_defines.svh"

module sqce_checker
    import sqce_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input sqce_out_t rsp
);

    // a stalled result holds
    `SQCE_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled result changed")

    // one transaction at a time: never two accepts back to back
    `SQCE_ASSERT_NEXT(a_no_b2b, clk, rst_n, req_valid && req_ready, !req_ready, "request accepted while busy")

    // a carried value always comes with ok status
    `SQCE_ASSERT_NOW(a_value_ok, clk, rst_n, rsp_valid && rsp.has_value, rsp.status == ST_OK, "value with error status")

    // no value means zero value
    `SQCE_ASSERT_NOW(a_zero_value, clk, rst_n, rsp_valid && !rsp.has_value, rsp.out_value == 32'sd0, "stray result value")

endmodule

bind stack_queue_command_engine_unit sqce_checker u_sqce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
